// File: rtl/cbc_pkg.sv
// ----------------------------------------------------------------------------
// cbc_pkg: shared types and constants for the circle/box contact pipeline
// Region codes, fixed widths and the sideband record that rides the pipe.
// ----------------------------------------------------------------------------
`default_nettype none

package cbc_pkg;

  localparam int CW       = 30;  // coordinate width, signed Q14.16
  localparam int UW       = 29;  // radius / size width, unsigned Q13.16
  localparam int NW       = 16;  // normal width, signed Q2.14
  localparam int SQ_STEPS = 31;  // root bits of a 62-bit radicand
  localparam int DV_STEPS = 15;  // quotient bits of the normal divide
  localparam int RAD_W    = 62;
  localparam int NUM_W    = 45;

  localparam logic [3:0] REG_INSIDE = 4'd0;
  localparam logic [3:0] REG_TL     = 4'd1;
  localparam logic [3:0] REG_TR     = 4'd2;
  localparam logic [3:0] REG_TOP    = 4'd3;
  localparam logic [3:0] REG_BL     = 4'd4;
  localparam logic [3:0] REG_BR     = 4'd5;
  localparam logic [3:0] REG_BOTTOM = 4'd6;
  localparam logic [3:0] REG_LEFT   = 4'd7;
  localparam logic [3:0] REG_RIGHT  = 4'd8;

  localparam logic signed [NW-1:0] ONE_Q14 = 16'sd16384;

  typedef struct packed {
    logic                    hit;
    logic [3:0]              region;
    logic signed [CW-1:0]    px;
    logic signed [CW-1:0]    py;
    logic signed [NW-1:0]    nx;
    logic signed [NW-1:0]    ny;
    logic                    cnr;   // corner hit: normal comes from the divider
    logic                    sx;
    logic                    sy;
  } side_t;

endpackage

`default_nettype wire

// File: rtl/cbc_ifs.sv
// ----------------------------------------------------------------------------
// cbc_ifs: channel interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbc_in_if;
  logic              valid;
  logic              ready;
  logic signed [29:0] circle_x;
  logic signed [29:0] circle_y;
  logic [28:0]       circle_radius;
  logic signed [29:0] box_x;
  logic signed [29:0] box_y;
  logic [28:0]       box_width;
  logic [28:0]       box_height;
  modport source (output valid, circle_x, circle_y, circle_radius, box_x, box_y,
                  box_width, box_height, input ready);
  modport sink   (input valid, circle_x, circle_y, circle_radius, box_x, box_y,
                  box_width, box_height, output ready);
endinterface

interface cbc_out_if;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [3:0]        region;
  logic signed [29:0] contact_x;
  logic signed [29:0] contact_y;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  modport source (output valid, hit, region, contact_x, contact_y, normal_x, normal_y,
                  input ready);
  modport sink   (input valid, hit, region, contact_x, contact_y, normal_x, normal_y,
                  output ready);
endinterface

interface cbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [28:0] min_gap;
  modport source (output valid, min_gap, input ready);
  modport sink   (input valid, min_gap, output ready);
endinterface

`default_nettype wire

// File: rtl/circle_box_contact.sv
// ----------------------------------------------------------------------------
// circle_box_contact: circle versus axis-aligned box contact test
// A request passes the front, root and divide stages and an output register.
// Throughput: one request per cycle; the whole pipe holds while a result
// waits unaccepted. Synchronous active-low reset clears all valid bits and
// sets min_gap to zero; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_box_contact (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cbc_cfg_if.sink    cfg_ch,
  cbc_in_if.sink     in_ch,
  cbc_out_if.source  out_ch
);

  logic        en;
  logic [28:0] gap_r;

  logic                      f_v;
  logic [cbc_pkg::RAD_W-1:0] f_rad;
  logic [29:0]               f_ax, f_ay, s_ax, s_ay;
  cbc_pkg::side_t            f_sb, s_sb, d_sb;
  logic                      s_v, d_v;
  logic [30:0]               s_len;
  logic [14:0]               d_qx, d_qy;

  logic                      ov_r;
  logic                      hit_r;
  logic [3:0]                region_r;
  logic signed [29:0]        cx_r, cy_r;
  logic signed [15:0]        nx_r, ny_r, nx_nxt, ny_nxt;

  assign en = !ov_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= '0;
    end else if (cfg_ch.valid) begin
      gap_r <= cfg_ch.min_gap;
    end
  end

  cbc_front u_front (
    .clk, .rst_n, .en,
    .in_v          (in_ch.valid),
    .circle_x      (in_ch.circle_x),
    .circle_y      (in_ch.circle_y),
    .circle_radius (in_ch.circle_radius),
    .box_x         (in_ch.box_x),
    .box_y         (in_ch.box_y),
    .box_width     (in_ch.box_width),
    .box_height    (in_ch.box_height),
    .min_gap       (gap_r),
    .v_o (f_v), .rad_o (f_rad), .axn_o (f_ax), .ayn_o (f_ay), .sb_o (f_sb)
  );

  cbc_isqrt u_isqrt (
    .clk, .rst_n, .en,
    .v_i (f_v), .rad_i (f_rad), .axn_i (f_ax), .ayn_i (f_ay), .sb_i (f_sb),
    .v_o (s_v), .root_o (s_len), .axn_o (s_ax), .ayn_o (s_ay), .sb_o (s_sb)
  );

  cbc_div u_div (
    .clk, .rst_n, .en,
    .v_i (s_v), .len_i (s_len), .axn_i (s_ax), .ayn_i (s_ay), .sb_i (s_sb),
    .v_o (d_v), .qx_o (d_qx), .qy_o (d_qy), .sb_o (d_sb)
  );

  // corner hits take the divided normal, signed toward the circle
  always_comb begin
    nx_nxt = d_sb.nx;
    ny_nxt = d_sb.ny;
    if (d_sb.cnr) begin
      nx_nxt = d_sb.sx ? 16'(-{1'b0, d_qx}) : {1'b0, d_qx};
      ny_nxt = d_sb.sy ? 16'(-{1'b0, d_qy}) : {1'b0, d_qy};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r    <= d_sb.hit;
      region_r <= d_sb.region;
      cx_r     <= d_sb.px;
      cy_r     <= d_sb.py;
      nx_r     <= nx_nxt;
      ny_r     <= ny_nxt;
    end
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.hit       = hit_r;
  assign out_ch.region    = region_r;
  assign out_ch.contact_x = cx_r;
  assign out_ch.contact_y = cy_r;
  assign out_ch.normal_x  = nx_r;
  assign out_ch.normal_y  = ny_r;

endmodule

`default_nettype wire

// File: rtl/cbc_front.sv
// ----------------------------------------------------------------------------
// cbc_front: classify, distance test and normalize
// Six stages: regions/edges, squares, reach compare and zero count, shift,
// squares of the shifted offsets, radicand sum.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_v,
  input  wire logic signed [29:0]   circle_x,
  input  wire logic signed [29:0]   circle_y,
  input  wire logic [28:0]          circle_radius,
  input  wire logic signed [29:0]   box_x,
  input  wire logic signed [29:0]   box_y,
  input  wire logic [28:0]          box_width,
  input  wire logic [28:0]          box_height,
  input  wire logic [28:0]          min_gap,
  output logic                      v_o,
  output logic [cbc_pkg::RAD_W-1:0] rad_o,
  output logic [29:0]               axn_o,
  output logic [29:0]               ayn_o,
  output cbc_pkg::side_t            sb_o
);

  // stage 1 combinational
  logic signed [31:0] cx, cy, bx, by, hw, hh, lft, rgt, top, bot;
  logic signed [31:0] px, py, dx, dy, d;
  logic [29:0]        reach;
  logic               above, below, is_l, is_r, corner;
  cbc_pkg::side_t     sb1_nxt;

  logic [5:0]            v_r;
  cbc_pkg::side_t        sb1_r, sb2_r, sb3_r, sb4_r, sb5_r, sb6_r;
  logic [29:0]           ax1_r, ay1_r, reach1_r, ax2_r, ay2_r, ax3_r, ay3_r;
  logic                  corner1_r, corner2_r;
  logic [59:0]           sqx2_r, sqy2_r, r2_r, sqx5_r, sqy5_r;
  logic [4:0]            sh3_r;
  logic [29:0]           axn4_r, ayn4_r, axn5_r, ayn5_r, axn6_r, ayn6_r;
  logic [cbc_pkg::RAD_W-1:0] rad6_r;

  logic [60:0]    d2;
  logic           lt;
  cbc_pkg::side_t sb3_nxt;
  logic [29:0]    m;
  logic [4:0]     sh3_nxt;

  always_comb begin
    cx    = {{2{circle_x[29]}}, circle_x};
    cy    = {{2{circle_y[29]}}, circle_y};
    bx    = {{2{box_x[29]}}, box_x};
    by    = {{2{box_y[29]}}, box_y};
    hw    = {4'b0, box_width[28:1]};
    hh    = {4'b0, box_height[28:1]};
    reach = {1'b0, circle_radius} + {1'b0, min_gap};
    lft   = bx - hw;
    rgt   = bx + hw;
    top   = by - hh;
    bot   = by + hh;
    above = cy < top;
    below = cy > bot;
    is_l  = cx < lft;
    is_r  = cx > rgt;
    sb1_nxt = '0;
    corner  = 1'b0;
    px = '0;
    py = '0;
    d  = '0;
    if (above || below) begin
      if (is_l || is_r) begin
        sb1_nxt.region = above ? (is_l ? cbc_pkg::REG_TL : cbc_pkg::REG_TR)
                               : (is_l ? cbc_pkg::REG_BL : cbc_pkg::REG_BR);
        px     = is_l ? lft : rgt;
        py     = above ? top : bot;
        corner = 1'b1;
      end else begin
        sb1_nxt.region = above ? cbc_pkg::REG_TOP : cbc_pkg::REG_BOTTOM;
        d = above ? (top - cy) : (cy - bot);
        if (d < $signed({2'b0, reach})) begin
          sb1_nxt.hit = 1'b1;
          px = cx;
          py = above ? top : bot;
          sb1_nxt.ny = above ? -cbc_pkg::ONE_Q14 : cbc_pkg::ONE_Q14;
        end
      end
    end else if (is_l || is_r) begin
      sb1_nxt.region = is_l ? cbc_pkg::REG_LEFT : cbc_pkg::REG_RIGHT;
      d = is_l ? (lft - cx) : (cx - rgt);
      if (d < $signed({2'b0, reach})) begin
        sb1_nxt.hit = 1'b1;
        px = is_l ? lft : rgt;
        py = cy;
        sb1_nxt.nx = is_l ? -cbc_pkg::ONE_Q14 : cbc_pkg::ONE_Q14;
      end
    end else begin
      sb1_nxt.hit = 1'b1;
    end
    sb1_nxt.px = px[29:0];
    sb1_nxt.py = py[29:0];
    dx = cx - px;
    dy = cy - py;
    sb1_nxt.sx = dx[31];
    sb1_nxt.sy = dy[31];
  end

  // stage 3 combinational: corner reach test and leading-zero count
  always_comb begin
    d2 = {1'b0, sqx2_r} + {1'b0, sqy2_r};
    lt = d2 < {1'b0, r2_r};
    sb3_nxt = sb2_r;
    if (corner2_r) begin
      sb3_nxt.hit = lt;
      sb3_nxt.cnr = lt;
      if (!lt) begin
        sb3_nxt.px = '0;
        sb3_nxt.py = '0;
      end
    end
    m = (ax2_r > ay2_r) ? ax2_r : ay2_r;
    sh3_nxt = '0;
    for (int i = 0; i < 30; i++) begin
      if (m[i]) sh3_nxt = 5'(29 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb1_r     <= sb1_nxt;
      ax1_r     <= dx[31] ? 30'(-dx) : dx[29:0];
      ay1_r     <= dy[31] ? 30'(-dy) : dy[29:0];
      reach1_r  <= reach;
      corner1_r <= corner;

      sqx2_r    <= ax1_r * ax1_r;
      sqy2_r    <= ay1_r * ay1_r;
      r2_r      <= reach1_r * reach1_r;
      ax2_r     <= ax1_r;
      ay2_r     <= ay1_r;
      sb2_r     <= sb1_r;
      corner2_r <= corner1_r;

      sb3_r <= sb3_nxt;
      sh3_r <= sh3_nxt;
      ax3_r <= ax2_r;
      ay3_r <= ay2_r;

      axn4_r <= ax3_r << sh3_r;
      ayn4_r <= ay3_r << sh3_r;
      sb4_r  <= sb3_r;

      sqx5_r <= axn4_r * axn4_r;
      sqy5_r <= ayn4_r * ayn4_r;
      axn5_r <= axn4_r;
      ayn5_r <= ayn4_r;
      sb5_r  <= sb4_r;

      rad6_r <= {2'b0, sqx5_r} + {2'b0, sqy5_r};
      axn6_r <= axn5_r;
      ayn6_r <= ayn5_r;
      sb6_r  <= sb5_r;
    end
  end

  assign v_o   = v_r[5];
  assign rad_o = rad6_r;
  assign axn_o = axn6_r;
  assign ayn_o = ayn6_r;
  assign sb_o  = sb6_r;

endmodule

`default_nettype wire

// File: rtl/cbc_isqrt.sv
// ----------------------------------------------------------------------------
// cbc_isqrt: pipelined integer square root
// One root bit per stage, restoring remainder form, floor result.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_isqrt (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      v_i,
  input  wire logic [cbc_pkg::RAD_W-1:0] rad_i,
  input  wire logic [29:0]               axn_i,
  input  wire logic [29:0]               ayn_i,
  input  wire cbc_pkg::side_t            sb_i,
  output logic                           v_o,
  output logic [30:0]                    root_o,
  output logic [29:0]                    axn_o,
  output logic [29:0]                    ayn_o,
  output cbc_pkg::side_t                 sb_o
);

  localparam int S = cbc_pkg::SQ_STEPS;

  logic                      v_r   [0:S];
  logic [31:0]               rem_r [0:S];
  logic [30:0]               root_r[0:S];
  logic [cbc_pkg::RAD_W-1:0] x_r   [0:S];
  logic [29:0]               ax_r  [0:S];
  logic [29:0]               ay_r  [0:S];
  cbc_pkg::side_t            sb_r  [0:S];

  assign v_r[0]    = v_i;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign x_r[0]    = rad_i;
  assign ax_r[0]   = axn_i;
  assign ay_r[0]   = ayn_i;
  assign sb_r[0]   = sb_i;

  for (genvar k = 0; k < S; k++) begin : g_step
    logic [33:0] rem_sh, trial;
    logic        ge;
    always_comb begin
      rem_sh = {rem_r[k], x_r[k][cbc_pkg::RAD_W-1 -: 2]};
      trial  = {1'b0, root_r[k], 2'b01};
      ge     = rem_sh >= trial;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? 32'(rem_sh - trial) : rem_sh[31:0];
        root_r[k+1] <= {root_r[k][29:0], ge};
        x_r[k+1]    <= x_r[k] << 2;
        ax_r[k+1]   <= ax_r[k];
        ay_r[k+1]   <= ay_r[k];
        sb_r[k+1]   <= sb_r[k];
      end
    end
  end

  assign v_o    = v_r[S];
  assign root_o = root_r[S];
  assign axn_o  = ax_r[S];
  assign ayn_o  = ay_r[S];
  assign sb_o   = sb_r[S];

endmodule

`default_nettype wire

// File: rtl/cbc_div.sv
// ----------------------------------------------------------------------------
// cbc_div: pipelined normal divide
// Rounded quotients |d|*2^14/L for both axes, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_div (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           v_i,
  input  wire logic [30:0]    len_i,
  input  wire logic [29:0]    axn_i,
  input  wire logic [29:0]    ayn_i,
  input  wire cbc_pkg::side_t sb_i,
  output logic                v_o,
  output logic [14:0]         qx_o,
  output logic [14:0]         qy_o,
  output cbc_pkg::side_t      sb_o
);

  localparam int S  = cbc_pkg::DV_STEPS;
  localparam int NW = cbc_pkg::NUM_W;

  logic           v_r  [0:S];
  logic [NW-1:0]  rx_r [0:S];
  logic [NW-1:0]  ry_r [0:S];
  logic [14:0]    qx_r [0:S];
  logic [14:0]    qy_r [0:S];
  logic [30:0]    l_r  [0:S];
  cbc_pkg::side_t sb_r [0:S];

  // prepare numerators with the half-divisor rounding term
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r[0] <= {1'b0, axn_i, 14'b0} + {15'b0, len_i[30:1]};
      ry_r[0] <= {1'b0, ayn_i, 14'b0} + {15'b0, len_i[30:1]};
      qx_r[0] <= '0;
      qy_r[0] <= '0;
      l_r[0]  <= len_i;
      sb_r[0] <= sb_i;
    end
  end

  for (genvar k = 0; k < S; k++) begin : g_step
    logic [NW:0] dvs;
    logic        gx, gy;
    always_comb begin
      dvs = {15'b0, l_r[k]} << (S - 1 - k);
      gx  = {1'b0, rx_r[k]} >= dvs;
      gy  = {1'b0, ry_r[k]} >= dvs;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rx_r[k+1] <= gx ? NW'({1'b0, rx_r[k]} - dvs) : rx_r[k];
        ry_r[k+1] <= gy ? NW'({1'b0, ry_r[k]} - dvs) : ry_r[k];
        qx_r[k+1] <= {qx_r[k][13:0], gx};
        qy_r[k+1] <= {qy_r[k][13:0], gy};
        l_r[k+1]  <= l_r[k];
        sb_r[k+1] <= sb_r[k];
      end
    end
  end

  assign v_o  = v_r[S];
  assign qx_o = qx_r[S];
  assign qy_o = qy_r[S];
  assign sb_o = sb_r[S];

endmodule

`default_nettype wire

// File: rtl/cbc_checker.sv
// ----------------------------------------------------------------------------
// cbc_checker: port-level checks for circle_box_contact
// Result-channel hold and consistency of hit, region, contact and normal.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              hit,
  input wire logic [3:0]        region,
  input wire logic signed [29:0] contact_x,
  input wire logic signed [29:0] contact_y,
  input wire logic signed [15:0] normal_x,
  input wire logic signed [15:0] normal_y
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(contact_x) && $stable(normal_x))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !hit |-> contact_x == 0 && contact_y == 0 && normal_x == 0 && normal_y == 0)
    else $error("miss with nonzero contact or normal");

  a_inside_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && region == cbc_pkg::REG_INSIDE |-> hit && normal_x == 0 && normal_y == 0)
    else $error("inside without hit");

  a_side_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && hit && (region == cbc_pkg::REG_TOP || region == cbc_pkg::REG_BOTTOM)
    |-> normal_x == 0 && (normal_y == 16384 || normal_y == -16384))
    else $error("bad side normal");

endmodule

bind circle_box_contact cbc_checker u_cbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .hit       (out_ch.hit),
  .region    (out_ch.region),
  .contact_x (out_ch.contact_x),
  .contact_y (out_ch.contact_y),
  .normal_x  (out_ch.normal_x),
  .normal_y  (out_ch.normal_y)
);

`default_nettype wire

// File: test/circle_box_contact_check.sv
// ----------------------------------------------------------------------------
// circle_box_contact_check: contact prediction and result comparison
// Watches the request, result and gap channels, predicts the contact for each
// accepted request and compares every accepted result with the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_box_contact_check (
  input  wire logic clk,
  input  wire logic rst_n,
  cbc_cfg_if        cfg_ch,
  cbc_in_if         in_ch,
  cbc_out_if        out_ch,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                          hit;
    logic [3:0]                    region;
    logic signed [cbc_pkg::CW-1:0] cx;
    logic signed [cbc_pkg::CW-1:0] cy;
    logic signed [cbc_pkg::NW-1:0] nx;
    logic signed [cbc_pkg::NW-1:0] ny;
  } contact_t;

  contact_t           contact_q[$];
  longint unsigned    gap;

  function automatic longint unsigned int_root(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Scale the larger magnitude into [2^29, 2^30) before the root and divide.
  function automatic void corner_normal(longint dx, longint dy, output longint nx,
                                        output longint ny);
    longint unsigned ax, ay, m, len, qx, qy;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    m = ax > ay ? ax : ay;
    nx = 0;
    ny = 0;
    if (m == 0) return;
    while (m >= (64'd1 << 30)) begin
      m >>= 1; ax >>= 1; ay >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      m <<= 1; ax <<= 1; ay <<= 1;
    end
    len = int_root(ax * ax + ay * ay);
    qx = (ax * 16384 + len / 2) / len;
    qy = (ay * 16384 + len / 2) / len;
    nx = dx < 0 ? -longint'(qx) : longint'(qx);
    ny = dy < 0 ? -longint'(qy) : longint'(qy);
  endfunction

  function automatic contact_t predict_contact(longint cx, longint cy, longint rad,
                                               longint bx, longint by, longint w,
                                               longint h);
    contact_t        res;
    longint          reach, lft, rgt, top, bot, px, py, nx, ny, dx, dy, d;
    longint unsigned d2, r2;
    logic            above, below, is_l, is_r, corner;
    reach = rad + longint'(gap);
    lft = bx - (w >>> 1);
    rgt = bx + (w >>> 1);
    top = by - (h >>> 1);
    bot = by + (h >>> 1);
    above = cy < top;
    below = cy > bot;
    is_l = cx < lft;
    is_r = cx > rgt;
    px = 0; py = 0; nx = 0; ny = 0;
    corner = 0;
    res.hit = 0;
    res.region = cbc_pkg::REG_INSIDE;
    if (above || below) begin
      if (is_l || is_r) begin
        if (above) res.region = is_l ? cbc_pkg::REG_TL : cbc_pkg::REG_TR;
        else res.region = is_l ? cbc_pkg::REG_BL : cbc_pkg::REG_BR;
        px = is_l ? lft : rgt;
        py = above ? top : bot;
        corner = 1;
      end else begin
        res.region = above ? cbc_pkg::REG_TOP : cbc_pkg::REG_BOTTOM;
        d = above ? top - cy : cy - bot;
        if (d < reach) begin
          res.hit = 1;
          px = cx;
          py = above ? top : bot;
          ny = above ? -16384 : 16384;
        end
      end
    end else if (is_l || is_r) begin
      res.region = is_l ? cbc_pkg::REG_LEFT : cbc_pkg::REG_RIGHT;
      d = is_l ? lft - cx : cx - rgt;
      if (d < reach) begin
        res.hit = 1;
        px = is_l ? lft : rgt;
        py = cy;
        nx = is_l ? -16384 : 16384;
      end
    end else begin
      res.hit = 1;
    end
    if (corner) begin
      dx = cx - px;
      dy = cy - py;
      d2 = longint'(dx * dx) + longint'(dy * dy);
      r2 = reach * reach;
      if (d2 < r2) begin
        res.hit = 1;
        corner_normal(dx, dy, nx, ny);
      end else begin
        px = 0;
        py = 0;
      end
    end
    res.cx = px[cbc_pkg::CW-1:0];
    res.cy = py[cbc_pkg::CW-1:0];
    res.nx = nx[cbc_pkg::NW-1:0];
    res.ny = ny[cbc_pkg::NW-1:0];
    return res;
  endfunction

  assign pending = contact_q.size();

  always @(posedge clk) begin
    contact_t exp_c;
    if (!rst_n) begin
      gap <= 0;
      fail_count <= 0;
      contact_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) gap <= cfg_ch.min_gap;
      if (in_ch.valid && in_ch.ready)
        contact_q = {contact_q, predict_contact(in_ch.circle_x, in_ch.circle_y,
          longint'(in_ch.circle_radius), in_ch.box_x, in_ch.box_y,
          longint'(in_ch.box_width), longint'(in_ch.box_height))};
      if (out_ch.valid && out_ch.ready) begin
        if (contact_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result at %0t", $time);
        end else begin
          exp_c = contact_q.pop_front();
          if (out_ch.hit !== exp_c.hit || out_ch.region !== exp_c.region ||
              out_ch.contact_x !== exp_c.cx || out_ch.contact_y !== exp_c.cy ||
              out_ch.normal_x !== exp_c.nx || out_ch.normal_y !== exp_c.ny) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("%0t exp hit %0d reg %0d c %0d,%0d n %0d,%0d got %0d %0d %0d,%0d %0d,%0d",
                $time, exp_c.hit, exp_c.region, exp_c.cx, exp_c.cy, exp_c.nx, exp_c.ny,
                out_ch.hit, out_ch.region, out_ch.contact_x, out_ch.contact_y,
                out_ch.normal_x, out_ch.normal_y);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: test/circle_box_contact_test.sv
// ----------------------------------------------------------------------------
// circle_box_contact_test: stimulus and verdict for the contact pipeline
// Directed region and extreme cases, then random near-box and full-range
// requests under several gap settings with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_box_contact_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE = 65536;
  localparam logic [cbc_pkg::UW-1:0] GAP_MAX = '1;

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count, pending;
  int   sent = 0;
  logic burst_mode = 0;

  cbc_cfg_if cfg_ch();
  cbc_in_if  in_ch();
  cbc_out_if out_ch();

  circle_box_contact u_dut (.clk(clk), .rst_n(rst_n), .cfg_ch(cfg_ch), .in_ch(in_ch),
                            .out_ch(out_ch));

  circle_box_contact_check u_check (.clk(clk), .rst_n(rst_n), .cfg_ch(cfg_ch),
    .in_ch(in_ch), .out_ch(out_ch), .fail_count(fail_count), .pending(pending));

  always #4 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(int cx, int cy, int rad, int bx, int by, int w, int h);
    int n;
    @(negedge clk);
    in_ch.valid = 1;
    in_ch.circle_x = cx[29:0];
    in_ch.circle_y = cy[29:0];
    in_ch.circle_radius = rad[28:0];
    in_ch.box_x = bx[29:0];
    in_ch.box_y = by[29:0];
    in_ch.box_width = w[28:0];
    in_ch.box_height = h[28:0];
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    n = idle_len();
    if (n > 0) begin
      @(negedge clk);
      in_ch.valid = 0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic write_gap(logic [cbc_pkg::UW-1:0] v);
    // drop the request line first so nothing enters while draining
    @(negedge clk);
    in_ch.valid = 0;
    wait (pending == 0);
    repeat (60) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1;
    cfg_ch.min_gap = v;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 0;
  endtask

  task automatic random_request();
    int bx, by, w, h, cx, cy, rad, span;
    if ($urandom_range(0, 4) == 0) begin
      send_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      span = 1 << $urandom_range(4, 26);
      bx = $urandom_range(0, 2 * span) - span;
      by = $urandom_range(0, 2 * span) - span;
      w = $urandom_range(0, span);
      h = $urandom_range(0, span);
      cx = bx + $urandom_range(0, 2 * w) - w;
      cy = by + $urandom_range(0, 2 * h) - h;
      rad = $urandom_range(0, span / 2);
      send_request(cx, cy, rad, bx, by, w, h);
    end
  endtask

  // Result side: random stalls, plus one long hold-off to back up the pipe.
  initial begin
    int   n;
    logic held;
    held = 0;
    out_ch.ready = 1;
    wait (sent >= 300);
    forever begin
      @(negedge clk);
      if (!held && sent >= 400) begin
        held = 1;
        out_ch.ready = 0;
        repeat (300) @(negedge clk);
      end
      n = idle_len();
      out_ch.ready = (n == 0);
      repeat (n) @(negedge clk);
      out_ch.ready = 1;
    end
  end

  initial begin
    logic [cbc_pkg::UW-1:0] gaps[5];
    in_ch.valid = 0;
    in_ch.circle_x = 0; in_ch.circle_y = 0; in_ch.circle_radius = 0;
    in_ch.box_x = 0; in_ch.box_y = 0; in_ch.box_width = 0; in_ch.box_height = 0;
    cfg_ch.valid = 0;
    cfg_ch.min_gap = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: inside, edge, each corner and side, hit and miss, extremes
    send_request(0, 0, 0, 0, 0, 4 * ONE, 4 * ONE);
    send_request(2 * ONE, 0, 0, 0, 0, 4 * ONE, 4 * ONE);
    send_request(-3 * ONE, -3 * ONE, 2 * ONE, 0, 0, 4 * ONE, 4 * ONE);
    send_request(-3 * ONE, -3 * ONE, ONE, 0, 0, 4 * ONE, 4 * ONE);
    send_request(3 * ONE, -3 * ONE, 2 * ONE, 0, 0, 4 * ONE, 4 * ONE);
    send_request(-3 * ONE, 3 * ONE, 2 * ONE, 0, 0, 4 * ONE, 4 * ONE);
    send_request(3 * ONE, 3 * ONE, 2 * ONE, 0, 0, 4 * ONE, 4 * ONE);
    send_request(3 * ONE, 3 * ONE, ONE, 0, 0, 4 * ONE, 4 * ONE);
    send_request(0, -3 * ONE, 2 * ONE, 0, 0, 4 * ONE, 4 * ONE);
    send_request(0, -3 * ONE, ONE, 0, 0, 4 * ONE, 4 * ONE);
    send_request(ONE, 3 * ONE, 2 * ONE, 0, 0, 4 * ONE, 4 * ONE);
    send_request(ONE, 3 * ONE, ONE, 0, 0, 4 * ONE, 4 * ONE);
    send_request(-3 * ONE, ONE, 2 * ONE, 0, 0, 4 * ONE, 4 * ONE);
    send_request(3 * ONE, -ONE, 2 * ONE, 0, 0, 4 * ONE, 4 * ONE);
    send_request(3 * ONE, -ONE, 0, 0, 0, 4 * ONE, 4 * ONE);
    send_request(5, 7, 9, 0, 0, 0, 0);
    send_request(0, 0, 0, 0, 0, 0, 0);
    send_request(-(1 << 29), -(1 << 29), (1 << 29) - 1, (1 << 29) - 1, (1 << 29) - 1,
                 (1 << 29) - 1, (1 << 29) - 1);
    send_request((1 << 29) - 1, (1 << 29) - 1, (1 << 29) - 1, -(1 << 29), -(1 << 29),
                 (1 << 29) - 1, (1 << 29) - 1);
    send_request((1 << 29) - 1, -(1 << 29), 0, -(1 << 29), (1 << 29) - 1, 0, 0);

    gaps[0] = GAP_MAX;
    gaps[1] = 0;
    gaps[2] = cbc_pkg::UW'(ONE / 2);
    gaps[3] = cbc_pkg::UW'($urandom);
    gaps[4] = cbc_pkg::UW'($urandom_range(0, 4095));
    foreach (gaps[p]) begin
      write_gap(gaps[p]);
      for (int i = 0; i < 326; i++) begin
        burst_mode = (i >= 100 && i < 160);
        random_request();
      end
      burst_mode = 0;
    end
    @(negedge clk);
    in_ch.valid = 0;

    wait (pending == 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
